// File: hw/rtl/sip_pkg.sv
// Shared types, widths and constants of the wheel speed incremental PID.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package sip_pkg;

  localparam int CntW     = 16;
  localparam int CntSW    = 17;
  localparam int SumW     = 18;
  localparam int MagW     = 17;
  localparam int SpeedW   = 13;
  localparam int ErrFullW = 14;
  localparam int ErrW     = 8;
  localparam int GainW    = 16;
  localparam int DiffW    = 9;
  localparam int Diff2W   = 10;
  localparam int ProdW    = 26;
  localparam int AccW     = 27;
  localparam int DriveW   = 20;
  localparam int AddrW    = 4;
  localparam int DataW    = 32;

  localparam int WrapLimit  = 30000;
  localparam int WrapOffset = 65535;
  localparam int ErrMax     = 80;
  localparam int DriveMax   = 512000;

  // Division by twenty as a multiplication by a reciprocal, exact for magnitudes below 2^18.
  localparam int               DivShift = 20;
  localparam int               DivProdW = MagW + 16;
  localparam logic [15:0]      DivRecip = 16'd52429;

  localparam logic signed [ErrFullW-1:0] ErrHi   = ErrFullW'(ErrMax);
  localparam logic signed [ErrFullW-1:0] ErrLo   = -ErrHi;
  localparam logic signed [AccW-1:0]     DriveHi = AccW'(DriveMax);
  localparam logic signed [AccW-1:0]     DriveLo = -DriveHi;

  typedef enum logic [1:0] {
    REG_SETPOINT = 2'd0,
    REG_PROP     = 2'd1,
    REG_INTEG    = 2'd2,
    REG_DERIV    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] speed_setpoint;
    logic signed [GainW-1:0]  prop_gain;
    logic signed [GainW-1:0]  integ_gain;
    logic signed [GainW-1:0]  deriv_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] speed;
    logic signed [ErrW-1:0]   err;
  } front_t;

  function automatic logic signed [CntSW-1:0] unwrap_count(input logic [CntW-1:0] raw);
    logic signed [CntSW-1:0] ext;
    ext = {1'b0, raw};
    if (raw >= CntW'(WrapLimit)) begin
      return ext - CntSW'(WrapOffset);
    end
    return ext;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sip_if.sv
// Valid/ready channel interfaces for the input beat and the result beat.
// Depends on sip_pkg for the field widths.
`default_nettype none

interface sip_in_if
  import sip_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [CntW-1:0] left_count;
  logic [CntW-1:0] right_count;

  modport source (output valid, output left_count, output right_count, input ready);
  modport sink   (input valid, input left_count, input right_count, output ready);
endinterface

interface sip_out_if
  import sip_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [SpeedW-1:0] measured_speed;
  logic signed [ErrW-1:0]   speed_error;
  logic signed [DriveW-1:0] drive_out;

  modport source (output valid, output measured_speed, output speed_error,
                  output drive_out, input ready);
  modport sink   (input valid, input measured_speed, input speed_error,
                  input drive_out, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sip_cfg.sv
// APB-style register file holding the setpoint and the three PID gains.
// Depends on sip_pkg.
`default_nettype none

module sip_cfg
  import sip_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_SETPOINT: cfg_nxt.speed_setpoint = pwdata[SpeedW-1:0];
        REG_PROP:     cfg_nxt.prop_gain      = pwdata[GainW-1:0];
        REG_INTEG:    cfg_nxt.integ_gain     = pwdata[GainW-1:0];
        REG_DERIV:    cfg_nxt.deriv_gain     = pwdata[GainW-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SETPOINT: prdata = {{(DataW-SpeedW){cfg_r.speed_setpoint[SpeedW-1]}},
                              cfg_r.speed_setpoint};
      REG_PROP:     prdata = {{(DataW-GainW){cfg_r.prop_gain[GainW-1]}}, cfg_r.prop_gain};
      REG_INTEG:    prdata = {{(DataW-GainW){cfg_r.integ_gain[GainW-1]}}, cfg_r.integ_gain};
      REG_DERIV:    prdata = {{(DataW-GainW){cfg_r.deriv_gain[GainW-1]}}, cfg_r.deriv_gain};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sip_front.sv
// Front stages: count unwrapping and wheel sum, then division by twenty and error clamp.
// Depends on sip_pkg and on the input channel interface.
`default_nettype none

module sip_front
  import sip_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  sip_in_if.sink                        in_chan,
  input  wire logic signed [SpeedW-1:0] speed_setpoint,
  output logic                          f_valid,
  input  wire logic                     f_ready,
  output front_t                        f_data
);

  logic                    a_valid_r;
  logic                    a_valid_nxt;
  logic [MagW-1:0]         a_mag_r;
  logic                    a_neg_r;
  logic                    a_ready;
  logic                    b_valid_r;
  logic                    b_valid_nxt;
  front_t                  b_data_r;
  front_t                  b_data_nxt;
  logic                    b_ready;

  logic signed [CntSW-1:0]    left_s;
  logic signed [CntSW-1:0]    right_s;
  logic signed [SumW-1:0]     wheel_sum;
  logic signed [SumW-1:0]     wheel_abs;
  logic [DivProdW-1:0]        div_prod;
  logic [SpeedW-1:0]          quot;
  logic signed [SpeedW-1:0]   speed;
  logic signed [ErrFullW-1:0] err_full;

  assign b_ready       = !b_valid_r || f_ready;
  assign a_ready       = !a_valid_r || b_ready;
  assign in_chan.ready = a_ready;
  assign f_valid       = b_valid_r;
  assign f_data        = b_data_r;

  assign left_s    = unwrap_count(in_chan.left_count);
  assign right_s   = unwrap_count(in_chan.right_count);
  assign wheel_sum = {left_s[CntSW-1], left_s} - {right_s[CntSW-1], right_s};
  assign wheel_abs = wheel_sum[SumW-1] ? -wheel_sum : wheel_sum;

  assign div_prod = DivProdW'(a_mag_r) * DivProdW'(DivRecip);
  assign quot     = div_prod[DivShift+SpeedW-1:DivShift];
  assign speed    = a_neg_r ? -signed'(quot) : signed'(quot);
  assign err_full = {speed_setpoint[SpeedW-1], speed_setpoint} - {speed[SpeedW-1], speed};

  always_comb begin
    b_data_nxt.speed = speed;
    if (err_full > ErrHi) begin
      b_data_nxt.err = ErrW'(ErrMax);
    end else if (err_full < ErrLo) begin
      b_data_nxt.err = -ErrW'(ErrMax);
    end else begin
      b_data_nxt.err = err_full[ErrW-1:0];
    end
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (a_ready) begin
      a_valid_nxt = in_chan.valid;
    end
    b_valid_nxt = b_valid_r;
    if (b_ready) begin
      b_valid_nxt = a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_chan.valid) begin
      a_mag_r <= wheel_abs[MagW-1:0];
      a_neg_r <= wheel_sum[SumW-1];
    end
    if (b_ready && a_valid_r) begin
      b_data_r <= b_data_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sip_pid.sv
// PID stages: gain products from the error history, then accumulation and saturation.
// Depends on sip_pkg and on the result channel interface.
`default_nettype none

module sip_pid
  import sip_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  input  wire logic   f_valid,
  output logic        f_ready,
  input  wire front_t f_data,
  sip_out_if.source   out_chan
);

  logic                     c_valid_r;
  logic                     c_valid_nxt;
  logic                     c_ready;
  logic signed [ProdW-1:0]  c_p_r;
  logic signed [ProdW-1:0]  c_i_r;
  logic signed [ProdW-1:0]  c_d_r;
  front_t                   c_data_r;
  logic signed [ErrW-1:0]   last_err_r;
  logic signed [ErrW-1:0]   prev_err_r;

  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic                     d_ready;
  front_t                   out_data_r;
  logic signed [DriveW-1:0] drive_r;
  logic signed [DriveW-1:0] drive_nxt;

  logic signed [DiffW-1:0]  diff1;
  logic signed [Diff2W-1:0] diff2;
  logic signed [GainW+DiffW-1:0]  prod_p;
  logic signed [GainW+ErrW-1:0]   prod_i;
  logic signed [GainW+Diff2W-1:0] prod_d;
  logic signed [AccW-1:0]   incr;
  logic signed [AccW-1:0]   acc;
  logic                     c_take;
  logic                     d_take;

  assign d_ready = !out_valid_r || out_chan.ready;
  assign c_ready = !c_valid_r || d_ready;
  assign f_ready = c_ready;
  assign c_take  = c_ready && f_valid;
  assign d_take  = d_ready && c_valid_r;

  assign diff1 = {f_data.err[ErrW-1], f_data.err} - {last_err_r[ErrW-1], last_err_r};
  assign diff2 = {{2{f_data.err[ErrW-1]}}, f_data.err}
               - {last_err_r[ErrW-1], last_err_r, 1'b0}
               + {{2{prev_err_r[ErrW-1]}}, prev_err_r};

  assign prod_p = cfg.prop_gain * diff1;
  assign prod_i = cfg.integ_gain * f_data.err;
  assign prod_d = cfg.deriv_gain * diff2;

  assign incr = {c_p_r[ProdW-1], c_p_r} + {c_i_r[ProdW-1], c_i_r} + {c_d_r[ProdW-1], c_d_r};
  assign acc  = {{(AccW-DriveW){drive_r[DriveW-1]}}, drive_r} + incr;

  always_comb begin
    if (acc > DriveHi) begin
      drive_nxt = DriveHi[DriveW-1:0];
    end else if (acc < DriveLo) begin
      drive_nxt = DriveLo[DriveW-1:0];
    end else begin
      drive_nxt = acc[DriveW-1:0];
    end
  end

  always_comb begin
    c_valid_nxt = c_valid_r;
    if (c_ready) begin
      c_valid_nxt = f_valid;
    end
    out_valid_nxt = out_valid_r;
    if (d_ready) begin
      out_valid_nxt = c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      last_err_r  <= '0;
      prev_err_r  <= '0;
      drive_r     <= '0;
    end else begin
      c_valid_r   <= c_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (c_take) begin
        last_err_r <= f_data.err;
        prev_err_r <= last_err_r;
      end
      if (d_take) begin
        drive_r <= drive_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_take) begin
      c_p_r    <= {prod_p[GainW+DiffW-1], prod_p};
      c_i_r    <= {{(ProdW-GainW-ErrW){prod_i[GainW+ErrW-1]}}, prod_i};
      c_d_r    <= prod_d;
      c_data_r <= f_data;
    end
    if (d_take) begin
      out_data_r <= c_data_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.measured_speed = out_data_r.speed;
  assign out_chan.speed_error    = out_data_r.err;
  assign out_chan.drive_out      = drive_r;

endmodule

`default_nettype wire

// File: hw/rtl/speed_incremental_pid.sv
// Top level of the wheel speed incremental PID: register file, front stages, PID stages.
// Depends on sip_pkg, sip_if, sip_cfg, sip_front and sip_pid.
//
//   Channel   Direction  Handshake             Payload
//   in_chan   in         valid/ready           left_count, right_count
//   out_chan  out        valid/ready           measured_speed, speed_error, drive_out
//   cfg       in         psel/penable/pready   paddr, pwdata, prdata
//
// An item passes four registered stages, a, b, c and the output register, the first loaded by
// the edge that accepts it.
// One item is taken in every cycle while out_chan.ready keeps the pipeline draining.
// Each stage holds its beat while the next one is full, so the output register stalls only as
// far back as needed. Synchronous active-low reset clears the valid flags, the register file,
// the error history and the drive sum; the data registers of the stages are not reset.
`default_nettype none

module speed_incremental_pid
  import sip_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  sip_in_if.sink                in_chan,
  sip_out_if.source             out_chan,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  cfg_t   cfg;
  logic   f_valid;
  logic   f_ready;
  front_t f_data;

  sip_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sip_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_chan        (in_chan),
    .speed_setpoint (cfg.speed_setpoint),
    .f_valid        (f_valid),
    .f_ready        (f_ready),
    .f_data         (f_data)
  );

  sip_pid u_pid (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_data   (f_data),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
